// File: hdl/rme_pkg.sv
// package for the register machine execute block: opcodes, status codes,
// arithmetic unit control types and the register index wrap function
// no dependencies
`default_nettype none

package rme_pkg;

    localparam int NUM_REGS_DEF  = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int OPC_BITS  = 4;
    localparam int IDX_BITS  = 4;
    localparam int IMM_BITS  = 32;
    localparam int STAT_BITS = 3;
    localparam int READ_BITS = 32;

    typedef enum logic [OPC_BITS-1:0] {
        OP_COPY   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_ADD    = 4'd2,
        OP_SUB    = 4'd3,
        OP_MUL    = 4'd4,
        OP_DIV    = 4'd5,
        OP_BEQ    = 4'd6,
        OP_HALT   = 4'd7,
        OP_PRESET = 4'd8,
        OP_READ   = 4'd9
    } t_opcode;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK       = 3'd0,
        ST_BRANCH   = 3'd1,
        ST_HALT     = 3'd2,
        ST_NEG_IMM  = 3'd3,
        ST_UNDEF    = 3'd4,
        ST_NEG_SUB  = 3'd5,
        ST_DIV_ZERO = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

    typedef struct packed {
        logic done;
        logic borrow;
    } t_alu_sts;

    // 4-bit register field reduced modulo the register count by compare-subtract
    function automatic logic [8:0] reg_wrap(input logic [IDX_BITS-1:0] raw,
                                            input int unsigned n);
        logic [8:0] v;
        v = {5'b0, raw};
        for (int k = 0; k < 8; k++) begin
            if (v >= 9'(n)) begin
                v = v - 9'(n);
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hdl/rme_if.sv
// request and result channel interfaces of the register machine execute block
// depends on rme_pkg
`default_nettype none

interface rme_in_if import rme_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OPC_BITS-1:0]        opcode;
    logic [IDX_BITS-1:0]        reg_a;
    logic [IDX_BITS-1:0]        reg_b;
    logic [IDX_BITS-1:0]        reg_dest;
    logic signed [IMM_BITS-1:0] immediate;
    logic                       preset_defined;

    modport source (output valid, opcode, reg_a, reg_b, reg_dest, immediate,
                    preset_defined, input ready);
    modport sink (input valid, opcode, reg_a, reg_b, reg_dest, immediate,
                  preset_defined, output ready);
endinterface

interface rme_out_if import rme_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STAT_BITS-1:0] status;
    logic [READ_BITS-1:0] read_value;
    logic                 read_defined;

    modport source (output valid, status, read_value, read_defined, input ready);
    modport sink (input valid, status, read_value, read_defined, output ready);
endinterface

`default_nettype wire

// File: hdl/register_machine_execute.sv
// register machine execute unit: top level with the instruction sequencer
// depends on rme_pkg, rme_if, rme_regfile and rme_alu
//
// usage:
//   i_req carries one instruction per request (opcode, register indexes,
//   immediate, preset flag); o_rsp returns exactly one result per request
//   (status, read value, read defined bit), in order.
//   one instruction is worked on at a time: i_req.ready is high only while
//   the sequencer is idle.
//   multiply and divide run on the shared adder, which does one bit per
//   cycle; add and sub use it once. a new request can be taken in the cycle
//   after the result is loaded into the output register.
//   the result sits in an output register; if o_rsp.ready is low the
//   sequencer finishes the next instruction and then waits before writing
//   its result until the register is free.
//   reset clears all defined bits (every register reads undefined, zero),
//   the sequencer and the output valid; register values need no clearing.
`default_nettype none

module register_machine_execute import rme_pkg::*; #(
    parameter int NUM_REGS  = NUM_REGS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rme_in_if.sink    i_req,
    rme_out_if.source o_rsp
);

    localparam int IDX_W = $clog2(NUM_REGS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_EXEC = 5'b00100,
        S_WAIT = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [OPC_BITS-1:0]  r_op;
    logic [IDX_W-1:0]     r_ia, r_ib, r_id;
    logic [IMM_BITS-1:0]  r_imm;
    logic                 r_pdef;

    t_status              r_status, n_status;
    logic [READ_BITS-1:0] r_rv, n_rv;
    logic                 r_rd, n_rd;

    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status;
    logic [READ_BITS-1:0] r_out_rv;
    logic                 r_out_rd;

    logic                 accept;
    logic                 out_load;
    logic [8:0]           wrap_a, wrap_b, wrap_d;
    logic [WORD_BITS-1:0] imm_w;

    logic [WORD_BITS-1:0] rf_va, rf_vb;
    logic                 rf_da, rf_db;
    logic                 rf_wr_en;
    logic [WORD_BITS-1:0] rf_wr_val;
    logic                 rf_wr_def;

    t_alu_ctl             alu_ctl;
    t_alu_sts             alu_sts;
    logic [WORD_BITS-1:0] alu_result;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    assign wrap_a = reg_wrap(i_req.reg_a, NUM_REGS);
    assign wrap_b = reg_wrap(i_req.reg_b, NUM_REGS);
    assign wrap_d = reg_wrap(i_req.reg_dest, NUM_REGS);

    assign imm_w = WORD_BITS'(r_imm);

    rme_regfile #(
        .NUM_REGS  (NUM_REGS),
        .WORD_BITS (WORD_BITS)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr_a (r_ia),
        .i_rd_addr_b (r_ib),
        .o_rd_val_a  (rf_va),
        .o_rd_val_b  (rf_vb),
        .o_rd_def_a  (rf_da),
        .o_rd_def_b  (rf_db),
        .i_wr_en     (rf_wr_en),
        .i_wr_addr   (r_id),
        .i_wr_val    (rf_wr_val),
        .i_wr_def    (rf_wr_def)
    );

    rme_alu #(
        .WORD_BITS (WORD_BITS)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (alu_ctl),
        .i_a      (rf_va),
        .i_b      (rf_vb),
        .o_sts    (alu_sts),
        .o_result (alu_result)
    );

    always_comb begin
        n_state       = r_state;
        n_status      = r_status;
        n_rv          = r_rv;
        n_rd          = r_rd;
        rf_wr_en      = 1'b0;
        rf_wr_val     = imm_w;
        rf_wr_def     = 1'b1;
        alu_ctl.start = 1'b0;
        alu_ctl.op    = ALU_ADD;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_rv     = '0;
                n_rd     = 1'b0;
                n_state  = S_DONE;
                case (r_op)
                    OP_COPY: begin
                        rf_wr_en  = 1'b1;
                        rf_wr_val = rf_va;
                        rf_wr_def = rf_da;
                    end
                    OP_LOAD: begin
                        if (r_imm[IMM_BITS-1]) begin
                            n_status = ST_NEG_IMM;
                        end else begin
                            rf_wr_en = 1'b1;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        if (!(rf_da && rf_db)) begin
                            n_status = ST_UNDEF;
                        end else if (r_op == OP_DIV && rf_vb == '0) begin
                            n_status = ST_DIV_ZERO;
                        end else begin
                            alu_ctl.start = 1'b1;
                            case (r_op)
                                OP_SUB:  alu_ctl.op = ALU_SUB;
                                OP_MUL:  alu_ctl.op = ALU_MUL;
                                OP_DIV:  alu_ctl.op = ALU_DIV;
                                default: alu_ctl.op = ALU_ADD;
                            endcase
                            n_state = S_WAIT;
                        end
                    end
                    OP_BEQ: begin
                        if (!(rf_da && rf_db)) begin
                            n_status = ST_UNDEF;
                        end else if (rf_va == rf_vb) begin
                            n_status = ST_BRANCH;
                        end
                    end
                    OP_HALT: begin
                        n_status = ST_HALT;
                    end
                    OP_PRESET: begin
                        rf_wr_en  = 1'b1;
                        rf_wr_val = r_pdef ? imm_w : '0;
                        rf_wr_def = r_pdef;
                    end
                    OP_READ: begin
                        n_rv = READ_BITS'(rf_va);
                        n_rd = rf_da;
                    end
                    default: ;
                endcase
            end
            S_WAIT: begin
                if (alu_sts.done) begin
                    if (r_op == OP_SUB && alu_sts.borrow) begin
                        n_status = ST_NEG_SUB;
                    end else begin
                        rf_wr_en  = 1'b1;
                        rf_wr_val = alu_result;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_req.opcode;
            r_ia   <= wrap_a[IDX_W-1:0];
            r_ib   <= wrap_b[IDX_W-1:0];
            r_id   <= wrap_d[IDX_W-1:0];
            r_imm  <= i_req.immediate;
            r_pdef <= i_req.preset_defined;
        end
        r_status <= n_status;
        r_rv     <= n_rv;
        r_rd     <= n_rd;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_rv     <= r_rv;
            r_out_rd     <= r_rd;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.read_value   = r_out_rv;
    assign o_rsp.read_defined = r_out_rd;

    // the arithmetic unit only finishes while the sequencer waits for it
    a_alu_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_sts.done |-> r_state == S_WAIT)
        else $error("arithmetic unit finished outside the wait state");

    // an accepted request always goes on to the register read
    a_accept_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_RD)
        else $error("accepted request did not start a register read");

    // register writes come only from execute or arithmetic completion
    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_wr_en |-> (r_state == S_EXEC || (r_state == S_WAIT && alu_sts.done)))
        else $error("register file written outside execution");

endmodule

`default_nettype wire

// File: hdl/rme_regfile.sv
// register file: value memory with two registered read ports and one write
// port, plus a defined bit per register cleared at reset; depends on rme_pkg
`default_nettype none

module rme_regfile import rme_pkg::*; #(
    parameter int NUM_REGS  = NUM_REGS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [$clog2(NUM_REGS)-1:0]  i_rd_addr_a,
    input  logic [$clog2(NUM_REGS)-1:0]  i_rd_addr_b,
    output logic [WORD_BITS-1:0]         o_rd_val_a,
    output logic [WORD_BITS-1:0]         o_rd_val_b,
    output logic                         o_rd_def_a,
    output logic                         o_rd_def_b,
    input  logic                         i_wr_en,
    input  logic [$clog2(NUM_REGS)-1:0]  i_wr_addr,
    input  logic [WORD_BITS-1:0]         i_wr_val,
    input  logic                         i_wr_def
);

    logic [WORD_BITS-1:0] mem [NUM_REGS];
    logic [NUM_REGS-1:0]  r_def;
    logic [WORD_BITS-1:0] r_rd_a;
    logic [WORD_BITS-1:0] r_rd_b;
    logic                 r_def_a;
    logic                 r_def_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_val;
        end
        r_rd_a <= mem[i_rd_addr_a];
        r_rd_b <= mem[i_rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def   <= '0;
            r_def_a <= 1'b0;
            r_def_b <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_def[i_wr_addr] <= i_wr_def;
            end
            r_def_a <= r_def[i_rd_addr_a];
            r_def_b <= r_def[i_rd_addr_b];
        end
    end

    // an undefined register always reads as zero, memory is never cleared
    assign o_rd_val_a = r_def_a ? r_rd_a : '0;
    assign o_rd_val_b = r_def_b ? r_rd_b : '0;
    assign o_rd_def_a = r_def_a;
    assign o_rd_def_b = r_def_b;

endmodule

`default_nettype wire

// File: hdl/rme_alu.sv
// shared arithmetic unit: one adder/subtractor used once for add and sub,
// and once per bit for shift-add multiply and restoring divide; depends on rme_pkg
`default_nettype none

module rme_alu import rme_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_alu_ctl             i_ctl,
    input  logic [WORD_BITS-1:0] i_a,
    input  logic [WORD_BITS-1:0] i_b,
    output t_alu_sts             o_sts,
    output logic [WORD_BITS-1:0] o_result
);

    localparam int CNT_W = $clog2(WORD_BITS);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_borrow;
    t_alu_op              r_op;
    logic [CNT_W-1:0]     r_cnt;
    logic [WORD_BITS-1:0] r_acc;
    logic [WORD_BITS-1:0] r_q;
    logic [WORD_BITS-1:0] r_b;

    logic                 is_sub;
    logic [WORD_BITS:0]   t;
    logic [WORD_BITS-1:0] y;
    logic [WORD_BITS+1:0] sum;

    always_comb begin
        is_sub = (r_op == ALU_SUB) || (r_op == ALU_DIV);
        case (r_op)
            ALU_MUL: t = {r_acc, 1'b0};
            ALU_DIV: t = {r_acc, r_q[WORD_BITS-1]};
            default: t = {1'b0, r_q};
        endcase
        y   = (r_op == ALU_MUL && !r_q[WORD_BITS-1]) ? '0 : r_b;
        // top bit of sum is the borrow when subtracting
        sum = {1'b0, t} + (is_sub ? ~{2'b0, y} : {2'b0, y}) + (WORD_BITS+2)'(is_sub);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= ALU_ADD;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_op   <= i_ctl.op;
                r_cnt  <= CNT_W'(WORD_BITS - 1);
            end else if (r_busy) begin
                if (r_op == ALU_ADD || r_op == ALU_SUB || r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_q      <= i_a;
            r_b      <= i_b;
            r_acc    <= '0;
            r_borrow <= 1'b0;
        end else if (r_busy) begin
            case (r_op)
                ALU_ADD, ALU_SUB: begin
                    r_acc    <= sum[WORD_BITS-1:0];
                    r_borrow <= sum[WORD_BITS+1];
                end
                ALU_MUL: begin
                    r_acc <= sum[WORD_BITS-1:0];
                    r_q   <= {r_q[WORD_BITS-2:0], 1'b0};
                end
                ALU_DIV: begin
                    // restore on borrow, quotient bit shifts in from the right
                    r_acc <= sum[WORD_BITS+1] ? t[WORD_BITS-1:0] : sum[WORD_BITS-1:0];
                    r_q   <= {r_q[WORD_BITS-2:0], ~sum[WORD_BITS+1]};
                end
                default: ;
            endcase
        end
    end

    assign o_sts    = '{done: r_done, borrow: r_borrow};
    assign o_result = (r_op == ALU_DIV) ? r_q : r_acc;

endmodule

`default_nettype wire

// File: bench/rme_result_checker.sv
`timescale 1ns / 1ps
// result checker for the register machine execute block: keeps its own copy of
// the register file, predicts the result of every accepted request, compares in order
// depends on rme_pkg and rme_if
module rme_result_checker import rme_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    rme_in_if    i_req,
    rme_out_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int NREGS = NUM_REGS_DEF;
    localparam int WBITS = WORD_BITS_DEF;

    typedef struct packed {
        t_status              status;
        logic [READ_BITS-1:0] read_value;
        logic                 read_defined;
    } t_result;

    logic [WBITS-1:0] mirror_value [NREGS];
    logic             mirror_defined [NREGS];
    t_result          results_due [$];

    // undefined registers always hold zero
    function automatic void write_mirror(input int idx, input logic [WBITS-1:0] val,
                                         input logic def);
        mirror_defined[idx] = def;
        mirror_value[idx]   = def ? val : '0;
    endfunction

    function automatic t_result execute_instruction(
        input logic [OPC_BITS-1:0] opcode,
        input logic [IDX_BITS-1:0] ra,
        input logic [IDX_BITS-1:0] rb,
        input logic [IDX_BITS-1:0] rd,
        input logic [IMM_BITS-1:0] imm,
        input logic                pdef
    );
        int               ia;
        int               ib;
        int               id;
        logic [WBITS-1:0] va;
        logic [WBITS-1:0] vb;
        logic             both_def;
        t_result          res;
        ia       = int'(ra) % NREGS;
        ib       = int'(rb) % NREGS;
        id       = int'(rd) % NREGS;
        va       = mirror_value[ia];
        vb       = mirror_value[ib];
        both_def = mirror_defined[ia] && mirror_defined[ib];
        res.status       = ST_OK;
        res.read_value   = '0;
        res.read_defined = 1'b0;
        case (opcode)
            OP_COPY: write_mirror(id, va, mirror_defined[ia]);
            OP_LOAD: begin
                if (imm[IMM_BITS-1]) begin
                    res.status = ST_NEG_IMM;
                end else begin
                    write_mirror(id, WBITS'(imm), 1'b1);
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                // undefined sources win over negative result and zero divisor
                if (!both_def) begin
                    res.status = ST_UNDEF;
                end else if (opcode == OP_ADD) begin
                    write_mirror(id, va + vb, 1'b1);
                end else if (opcode == OP_SUB) begin
                    if (va >= vb) begin
                        write_mirror(id, va - vb, 1'b1);
                    end else begin
                        res.status = ST_NEG_SUB;
                    end
                end else if (opcode == OP_MUL) begin
                    write_mirror(id, va * vb, 1'b1);
                end else if (vb == '0) begin
                    res.status = ST_DIV_ZERO;
                end else begin
                    write_mirror(id, va / vb, 1'b1);
                end
            end
            OP_BEQ: begin
                if (!both_def) begin
                    res.status = ST_UNDEF;
                end else if (va == vb) begin
                    res.status = ST_BRANCH;
                end
            end
            OP_HALT: res.status = ST_HALT;
            OP_PRESET: write_mirror(id, WBITS'(imm), pdef);
            OP_READ: begin
                res.read_value   = READ_BITS'(mirror_value[ia]);
                res.read_defined = mirror_defined[ia];
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < NREGS; k++) begin
                mirror_value[k]   = '0;
                mirror_defined[k] = 1'b0;
            end
            results_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.status       = t_status'(i_rsp.status);
                got.read_value   = i_rsp.read_value;
                got.read_defined = i_rsp.read_defined;
                if (results_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result: expected none, got status %0d value %h def %b",
                             $time, got.status, got.read_value, got.read_defined);
                end else begin
                    want = results_due.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        $display("%0t: mismatch: expected status %0d value %h def %b, %s",
                                 $time, want.status, want.read_value, want.read_defined,
                                 $sformatf("got status %0d value %h def %b",
                                           got.status, got.read_value, got.read_defined));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                results_due.push_back(execute_instruction(i_req.opcode, i_req.reg_a,
                                      i_req.reg_b, i_req.reg_dest, i_req.immediate,
                                      i_req.preset_defined));
            end
        end
        o_pending = results_due.size();
    end

endmodule

// File: bench/register_machine_execute_test.sv
`timescale 1ns / 1ps
// top of the register machine execute bench: clock, reset, request stimulus and
// response back-pressure; depends on rme_pkg, rme_if, the block and rme_result_checker
module register_machine_execute_test;

    import rme_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int QUIET_ITEMS  = 200;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RESET_CYCLES = 12;

    localparam int OPC_FIRST_UNUSED = 10;
    localparam int OPC_LAST         = 15;
    localparam int REG_LAST         = 15;
    localparam int REG_POOL_LAST    = 3;

    localparam logic [IMM_BITS-1:0] IMM_MAX  = 32'h7fff_ffff;
    localparam logic [IMM_BITS-1:0] IMM_MIN  = 32'h8000_0000;
    localparam logic [IMM_BITS-1:0] IMM_ONES = '1;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycles     = 0;
    int   stall_left = 0;
    int   stall_odds = 0;
    int   gap_odds   = 0;

    rme_in_if  req_ch();
    rme_out_if rsp_ch();

    register_machine_execute dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    rme_result_checker result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // response stalls come in bursts, started at random with odds of stall_odds in 16
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end else if (stall_odds > 0 && $urandom_range(0, 15) < stall_odds) begin
            stall_left = $urandom_range(0, 12);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    task automatic issue_request(input logic [OPC_BITS-1:0] opcode,
                                 input logic [IDX_BITS-1:0] ra,
                                 input logic [IDX_BITS-1:0] rb,
                                 input logic [IDX_BITS-1:0] rd,
                                 input logic [IMM_BITS-1:0] imm,
                                 input logic                pdef);
        req_ch.valid          <= 1'b1;
        req_ch.opcode         <= opcode;
        req_ch.reg_a          <= ra;
        req_ch.reg_b          <= rb;
        req_ch.reg_dest       <= rd;
        req_ch.immediate      <= imm;
        req_ch.preset_defined <= pdef;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic idle_gap();
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // half the picks come from a small pool so sources are often defined and equal
    function automatic logic [IDX_BITS-1:0] pick_reg();
        if ($urandom_range(0, 1) == 0) begin
            return IDX_BITS'($urandom_range(0, REG_LAST));
        end
        return IDX_BITS'($urandom_range(0, REG_POOL_LAST));
    endfunction

    function automatic logic [IMM_BITS-1:0] pick_imm();
        case ($urandom_range(0, 7))
            0: return IMM_MAX;
            1: return IMM_MIN;
            2: return IMM_ONES;
            3: return '0;
            4, 5: return IMM_BITS'($urandom_range(0, 20));
            default: return $urandom() >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [OPC_BITS-1:0] pick_opcode();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 7) return OP_COPY;
        if (roll < 17) return OP_LOAD;
        if (roll < 29) return OP_ADD;
        if (roll < 41) return OP_SUB;
        if (roll < 51) return OP_MUL;
        if (roll < 63) return OP_DIV;
        if (roll < 71) return OP_BEQ;
        if (roll < 74) return OP_HALT;
        if (roll < 85) return OP_PRESET;
        if (roll < 95) return OP_READ;
        return OPC_BITS'($urandom_range(OPC_FIRST_UNUSED, OPC_LAST));
    endfunction

    initial begin
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.opcode         <= '0;
        req_ch.reg_a          <= '0;
        req_ch.reg_b          <= '0;
        req_ch.reg_dest       <= '0;
        req_ch.immediate      <= '0;
        req_ch.preset_defined <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        stall_odds = 4;

        // every register starts out undefined
        issue_request(OP_READ, 0, 0, 0, '0, 1'b0);
        issue_request(OP_ADD, 0, 1, 2, '0, 1'b0);
        issue_request(OP_COPY, 0, 0, 1, '0, 1'b0);
        issue_request(OP_LOAD, 0, 0, 2, IMM_MAX, 1'b0);
        issue_request(OP_LOAD, 0, 0, 3, IMM_MIN, 1'b1);
        issue_request(OP_LOAD, 0, 0, 3, '0, 1'b0);
        // preset keeps raw bits of a negative immediate
        issue_request(OP_PRESET, 0, 0, 4, IMM_ONES, 1'b1);
        issue_request(OP_PRESET, 0, 0, 5, 32'h1234_5678, 1'b0);
        issue_request(OP_READ, 5, 0, 0, '0, 1'b0);
        issue_request(OP_READ, 4, 0, 0, '0, 1'b0);
        issue_request(OP_ADD, 4, 4, 6, '0, 1'b0);
        issue_request(OP_MUL, 4, 4, 7, '0, 1'b0);
        issue_request(OP_SUB, 3, 2, 8, '0, 1'b0);
        issue_request(OP_SUB, 2, 3, 8, '0, 1'b0);
        // undefined source is reported ahead of negative result and zero divisor
        issue_request(OP_SUB, 5, 2, 9, '0, 1'b0);
        issue_request(OP_DIV, 2, 5, 9, '0, 1'b0);
        issue_request(OP_DIV, 2, 3, 9, '0, 1'b0);
        issue_request(OP_DIV, 4, 2, 9, '0, 1'b0);
        issue_request(OP_BEQ, 2, 8, 0, '0, 1'b0);
        issue_request(OP_BEQ, 2, 3, 0, '0, 1'b0);
        issue_request(OP_BEQ, 2, 5, 0, '0, 1'b0);
        issue_request(OP_HALT, 0, 0, 0, IMM_ONES, 1'b1);
        issue_request(OPC_BITS'(OPC_LAST), IDX_BITS'(REG_LAST), IDX_BITS'(REG_LAST),
                      IDX_BITS'(REG_LAST), IMM_ONES, 1'b1);
        issue_request(OP_COPY, 4, 0, IDX_BITS'(REG_LAST), '0, 1'b0);
        issue_request(OP_READ, IDX_BITS'(REG_LAST), 0, 0, '0, 1'b0);
        drain_results();

        for (int sent = 0; sent < RANDOM_ITEMS; sent++) begin
            // idling levels change per stretch, zero leaves a stretch without gaps
            if (sent % 150 == 0) begin
                gap_odds   = $urandom_range(0, 4);
                stall_odds = $urandom_range(0, 6);
            end
            if (sent >= RANDOM_ITEMS - QUIET_ITEMS) begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            if (sent % 400 == 399) begin
                drain_results();
            end else if (gap_odds > 0 && $urandom_range(0, 15) < gap_odds) begin
                idle_gap();
            end
            issue_request(pick_opcode(), pick_reg(), pick_reg(), pick_reg(), pick_imm(),
                          $urandom_range(0, 7) != 0);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
